@@ hw/rtl/fbba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbba_pkg
// Shared types and constants of the free block bitmap allocator.
// ----------------------------------------------------------------------------
package fbba_pkg;

  // Fixed field widths
  localparam int IDX_W = 12;  // block number
  localparam int CNT_W = 13;  // block count and free count

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 13'd4096;

  // Request codes
  typedef enum logic [1:0] {
    ACT_READ = 2'd0,
    ACT_FREE = 2'd1,
    ACT_USED = 2'd2,
    ACT_FIND = 2'd3
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NONE  = 2'd2
  } status_t;

  // Control states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_SCAN,
    S_WAIT
  } state_t;

  typedef struct packed {
    action_t            action;
    logic [IDX_W-1:0]   block_index;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic               bit_value;
    logic [IDX_W-1:0]   found_index;
    logic [CNT_W-1:0]   free_total;
  } out_t;

endpackage

@@ hw/rtl/fbba_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbba_mem
// Bitmap word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbba_mem #(
  parameter int DEPTH  = 128,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/fbba_word_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbba_word_scan
// Finds the lowest set bit of one bitmap word under a mask of valid bits.
// ----------------------------------------------------------------------------
module fbba_word_scan #(
  parameter int WORD_BITS = 32,
  parameter int BIT_W     = 5
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [WORD_BITS-1:0] mask,
  output logic                 hit,
  output logic [BIT_W-1:0]     pos
);

  logic [WORD_BITS-1:0] cand;

  assign cand = word & mask;
  assign hit  = |cand;

  // Priority encoder, lowest bit wins
  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        pos = BIT_W'(b);
      end
    end
  end

endmodule

@@ hw/rtl/free_block_bitmap_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator
// Free block bitmap with read, mark free, mark used and find first free.
// ----------------------------------------------------------------------------
// The bitmap sits in a word memory with one read and one write port and
// registered read data; the block handles one item at a time. A read or
// mark does a word read, then a check and write back. A read or mark out of
// range, or a find with a block count of zero, is answered without a memory
// read. A find scans words from the first up to the one holding the first
// free block, at most ceil(bound / WORD_BITS) words. After reset a clearing
// pass writes every word to all used, during which no item is accepted;
// configuration writes are taken at any time. A result waiting in the output
// register does not keep the next item from being accepted.
// ----------------------------------------------------------------------------
module free_block_bitmap_allocator
  import fbba_pkg::*;
#(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  // block count register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int MAXB_W     = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W      = (MAXB_W > CNT_W) ? MAXB_W : CNT_W;

  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORD_COUNT - 1);
  localparam logic [CMP_W-1:0]  MAX_BOUND = CMP_W'(MAX_BLOCKS);
  localparam logic [CMP_W-1:0]  WORD_SPAN = CMP_W'(WORD_BITS);

  state_t state, state_next;

  logic [CNT_W-1:0]     block_count;
  logic [CNT_W-1:0]     free_count, count_next;
  logic [ADDR_W-1:0]    clr_addr;
  action_t              act;
  logic [ADDR_W-1:0]    word_addr;
  logic [BIT_W-1:0]     bit_pos;
  out_t                 pend;

  logic                 accept, out_free;
  logic [CMP_W-1:0]     bound, base, rem;
  logic [CMP_W-1:0]     in_idx;
  logic [ADDR_W-1:0]    in_word;
  logic [BIT_W-1:0]     in_bit;

  logic                 rd_en, wr_en;
  logic [ADDR_W-1:0]    rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  logic [WORD_BITS-1:0] scan_mask;
  logic                 scan_hit;
  logic [BIT_W-1:0]     scan_pos;
  logic                 last_word, old_bit, done;
  out_t                 res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Active bound and request address split
  assign bound   = (CMP_W'(block_count) > MAX_BOUND) ? MAX_BOUND : CMP_W'(block_count);
  assign in_idx  = CMP_W'(in_data.block_index);
  assign in_word = ADDR_W'(in_data.block_index / WORD_BITS);
  assign in_bit  = BIT_W'(in_data.block_index % WORD_BITS);

  // Scan window of the current word
  assign base      = CMP_W'(word_addr) * WORD_SPAN;
  assign rem       = bound - base;
  assign last_word = (rem <= WORD_SPAN);
  assign old_bit   = rd_data[bit_pos];

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      scan_mask[b] = (rem > CMP_W'(b));
    end
  end

  fbba_mem #(
    .DEPTH  (WORD_COUNT),
    .WIDTH  (WORD_BITS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fbba_word_scan #(
    .WORD_BITS (WORD_BITS),
    .BIT_W     (BIT_W)
  ) u_scan (
    .word (rd_data),
    .mask (scan_mask),
    .hit  (scan_hit),
    .pos  (scan_pos)
  );

  // Memory access, result and count update
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = word_addr;
    wr_en      = 1'b0;
    wr_addr    = word_addr;
    wr_data    = rd_data;
    done       = 1'b0;
    count_next = free_count;
    res        = '{status: ST_OK, bit_value: 1'b0, found_index: '0, free_total: free_count};
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_data.action == ACT_FIND) begin
            if (bound == '0) begin
              done       = 1'b1;
              res.status = ST_NONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
            end
          end else if (in_idx >= bound) begin
            done       = 1'b1;
            res.status = ST_RANGE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = in_word;
          end
        end
      end
      S_ACCESS: begin
        done          = 1'b1;
        res.bit_value = old_bit;
        if (act == ACT_FREE) begin
          wr_en            = 1'b1;
          wr_data[bit_pos] = 1'b1;
          if (!old_bit) begin
            count_next = free_count + 1'b1;
          end
        end else if (act == ACT_USED) begin
          wr_en            = 1'b1;
          wr_data[bit_pos] = 1'b0;
          if (old_bit) begin
            count_next = free_count - 1'b1;
          end
        end
        res.free_total = count_next;
      end
      S_SCAN: begin
        if (scan_hit) begin
          done            = 1'b1;
          res.bit_value   = 1'b1;
          res.found_index = IDX_W'(base + CMP_W'(scan_pos));
        end else if (last_word) begin
          done       = 1'b1;
          res.status = ST_NONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = word_addr + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (done) begin
          state_next = out_free ? S_IDLE : S_WAIT;
        end else if (accept) begin
          state_next = (in_data.action == ACT_FIND) ? S_SCAN : S_ACCESS;
        end
      end
      S_ACCESS: begin
        state_next = out_free ? S_IDLE : S_WAIT;
      end
      S_SCAN: begin
        if (done) begin
          state_next = out_free ? S_IDLE : S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      block_count <= BLOCK_COUNT_RST;
      free_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      free_count <= count_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        block_count <= cfg_data;
      end
      if ((done || state == S_WAIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act       <= in_data.action;
      word_addr <= (in_data.action == ACT_FIND) ? '0 : in_word;
      bit_pos   <= in_bit;
    end else if (state == S_SCAN && !done) begin
      word_addr <= word_addr + 1'b1;
    end
    if (done && out_free) begin
      out_data <= res;
    end else if (state == S_WAIT && out_free) begin
      out_data <= pend;
    end
    if (done && !out_free) begin
      pend <= res;
    end
  end

endmodule
